[hw/rtl/ptdw_pkg.sv]
package ptdw_pkg;

    localparam int FREQ_W  = 32;
    localparam int QUOT_W  = 19;

    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_CABLE     = 2'd1;
    localparam logic [1:0] KIND_SATELLITE = 2'd2;

    localparam logic [31:0] CABLE_IF_HZ     = 32'd36125000;
    localparam logic [QUOT_W-1:0] CABLE_BAND_HIGH = 19'd4017;
    localparam logic [QUOT_W-1:0] CABLE_BAND_LOW  = 19'd2737;
    localparam logic [31:0] SAT_OFFSET_KHZ  = 32'd479500;
    localparam logic [9:0]  SAT_KHZ_TO_HZ   = 10'd1000;
    localparam logic [31:0] SAT_PRESCALE_HZ = 32'd2000000000;
    localparam logic [QUOT_W-1:0] SAT_DIV_LIMIT = 19'h3fff;

    // For every 32-bit x, (x * RECIP_MULT) >> RECIP_SHIFT equals x / 15625.
    localparam logic [31:0] RECIP_MULT  = 32'd2251799814;
    localparam int          RECIP_SHIFT = 45;

    localparam logic [7:0] SAT_BYTE1_BASE   = 8'h20;
    localparam logic [7:0] CABLE_BYTE2_BASE = 8'h84;
    localparam logic [7:0] CABLE_BYTE0_MASK = 8'h7f;
    localparam logic [7:0] BAND_HIGH_CODE   = 8'h04;
    localparam logic [7:0] BAND_LOW_CODE    = 8'h02;
    localparam logic [7:0] BAND_MID_CODE    = 8'h01;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic finish;
    } ptdw_cmd_t;

    typedef struct packed {
        logic out_free;
    } ptdw_status_t;

endpackage

[hw/rtl/pll_tuner_divider_word.sv]
// Path: an input transfer loads the frequency register, then the dividend is formed,
// then the reciprocal multiplication by 1/15625 is registered, then the output
// register is loaded. Flow: the four controller states hold one item at a time and
// take no input until it is through; the next input is taken while a finished result
// waits in the output register, and a new result waits in the last state until the
// output register is free. Reset: synchronous, active low; clears tuner_kind to 0 and empties the output.
module pll_tuner_divider_word
    import ptdw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        tuner_kind_we,
    input  logic [1:0]  tuner_kind_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] frequency
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] word_byte0, [15:8] word_byte1,
                                   // [23:16] word_byte2, [31:24] word_byte3
    output logic [0:0]  m_tuser    // [0] write_valid
);

    logic [1:0]   tuner_kind_reg;
    logic         idle;
    ptdw_cmd_t    cmd;
    ptdw_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tuner_kind_reg <= KIND_NONE;
        end else if (tuner_kind_we) begin
            tuner_kind_reg <= tuner_kind_wdata;
        end
    end

    assign s_tready = idle;

    ptdw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_tvalid),
        .idle    (idle),
        .status  (status),
        .cmd     (cmd)
    );

    ptdw_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .frequency       (s_tdata),
        .tuner_kind      (tuner_kind_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_write_valid (m_tuser[0]),
        .out_word        (m_tdata)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("no-write result carries nonzero bytes");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result written over an untaken result");
`endif

endmodule

[hw/rtl/ptdw_ctrl.sv]
module ptdw_ctrl
    import ptdw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    output logic         idle,
    input  ptdw_status_t status,
    output ptdw_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/ptdw_datapath.sv]
module ptdw_datapath
    import ptdw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ptdw_cmd_t         cmd,
    output ptdw_status_t      status,
    input  logic [FREQ_W-1:0] frequency,
    input  logic [1:0]        tuner_kind,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_write_valid,
    output logic [31:0]       out_word
);

    logic [FREQ_W-1:0] freq_reg;
    logic [1:0]        kind_reg;
    logic [FREQ_W-1:0] dvd_reg, dvd_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              pe_reg, pe_next;
    logic              valid_reg;
    logic              wv_reg;
    logic [31:0]       word_reg, word_next;

    logic [31:0]       cable_sum;
    logic [31:0]       sat_sum;
    logic [31:0]       sat_prod;
    logic [63:0]       recip_prod;
    logic [QUOT_W-1:0] quot;
    logic [2:0]        shift_k;
    logic [QUOT_W-1:0] sat_d;
    logic [2:0]        sel;
    logic [2:0]        sel_pe;
    logic [7:0]        band;

    assign cable_sum  = freq_reg + CABLE_IF_HZ;
    assign sat_sum    = freq_reg + SAT_OFFSET_KHZ;
    assign sat_prod   = sat_sum * {22'd0, SAT_KHZ_TO_HZ};
    assign recip_prod = 64'(dvd_reg) * 64'(RECIP_MULT);
    assign quot       = quot_reg;

    always_comb begin
        shift_k = 3'd7;
        for (int i = 6; i >= 0; i--) begin
            if ((quot >> i) < SAT_DIV_LIMIT) begin
                shift_k = 3'(i);
            end
        end
        sat_d  = quot >> shift_k;
        sel    = 3'd7 - shift_k;
        sel_pe = sel + {2'b00, pe_reg};
        if (quot > CABLE_BAND_HIGH) begin
            band = BAND_HIGH_CODE;
        end else if (quot < CABLE_BAND_LOW) begin
            band = BAND_LOW_CODE;
        end else begin
            band = BAND_MID_CODE;
        end
    end

    always_comb begin
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        pe_next   = pe_reg;
        if (cmd.prep) begin
            if (kind_reg == KIND_CABLE) begin
                dvd_next = {3'b000, cable_sum[31:3]};
            end else begin
                dvd_next = sat_prod;
            end
            pe_next = (sat_prod >= SAT_PRESCALE_HZ);
        end
        if (cmd.step) begin
            quot_next = recip_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    always_comb begin
        case (kind_reg)
            KIND_CABLE: begin
                word_next[7:0]   = {1'b0, quot[14:8]} & CABLE_BYTE0_MASK;
                word_next[15:8]  = quot[7:0];
                word_next[23:16] = CABLE_BYTE2_BASE | {quot[16:15], 6'b000000};
                word_next[31:24] = band;
            end
            KIND_SATELLITE: begin
                word_next[7:0]   = 8'h00;
                word_next[15:8]  = SAT_BYTE1_BASE | {3'b000, sel_pe, pe_reg, sat_d[16]};
                word_next[23:16] = sat_d[15:8];
                word_next[31:24] = sat_d[7:0];
            end
            default: begin
                word_next = '0;
            end
        endcase
    end

    assign status.out_free = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            freq_reg <= frequency;
            kind_reg <= tuner_kind;
        end
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        pe_reg   <= pe_next;
        if (cmd.finish) begin
            word_reg <= word_next;
            wv_reg   <= (kind_reg == KIND_CABLE) || (kind_reg == KIND_SATELLITE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid       = valid_reg;
    assign out_write_valid = wv_reg;
    assign out_word        = word_reg;

endmodule
